/* sv/lpg_pkg.sv */
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared widths, operation codes and defaults for the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int unsigned FIELD_W          = 16;
  localparam int unsigned COLOR_W          = 16;
  localparam int unsigned COORD_BITS_DEF   = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

endpackage

/* sv/lpg_if.sv */
// ----------------------------------------------------------------------------
// Line pixel generator channels
// Valid/ready channels for line commands, pixels and the color register.
// ----------------------------------------------------------------------------
interface lpg_cmd_if
  import lpg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [FIELD_W-1:0] start_x;
  logic [FIELD_W-1:0] start_y;
  logic [FIELD_W-1:0] end_x;
  logic [FIELD_W-1:0] end_y;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, operation, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lpg_pix_if
  import lpg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] pixel_x;
  logic [FIELD_W-1:0] pixel_y;
  logic [COLOR_W-1:0] pixel_colour;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_colour, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_colour, last_pixel, output ready);
endinterface

interface lpg_cfg_if
  import lpg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/line_pixel_generator.sv */
// ----------------------------------------------------------------------------
// Line pixel generator
// A step accepted while a line is active shows its pixel in the cycle after acceptance.
// Throughput: one transaction per cycle while the pixel output is not stalled;
// the line state updates in the accepting cycle and a single output register holds the pixel.
// Reset: no line active, pixel color zero, output empty.
// ----------------------------------------------------------------------------
module line_pixel_generator
  import lpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lpg_cfg_if.sink   cfg_i,
  lpg_cmd_if.sink   cmd_i,
  lpg_pix_if.source pix_o
);

  localparam int unsigned ErrW   = COORD_BITS + 1;
  localparam int unsigned WideW  = COORD_BITS + 2;

  logic                  busy_q, busy_d;
  logic                  axis_run_q, axis_run_d;
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [COORD_BITS-1:0] span_x_q, span_x_d, span_y_q, span_y_d;
  logic                  x_down_q, x_down_d, y_down_q, y_down_d;
  logic signed [ErrW-1:0] err_q, err_d;
  logic [COLOR_W-1:0]    color_q;

  logic                  out_valid_q;
  logic [FIELD_W-1:0]    out_x_q, out_y_q;
  logic [COLOR_W-1:0]    out_color_q;
  logic                  out_last_q;

  logic                  accept;
  logic                  emit;
  logic                  last;
  logic [COORD_BITS-1:0] xs, ys, xe, ye;
  logic signed [WideW-1:0] twice, err_w, dx_w, dy_w;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = !out_valid_q || pix_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign emit        = accept && (cmd_i.operation == OP_STEP) && busy_q;
  assign last        = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);

  assign xs = cmd_i.start_x[COORD_BITS-1:0];
  assign ys = cmd_i.start_y[COORD_BITS-1:0];
  assign xe = cmd_i.end_x[COORD_BITS-1:0];
  assign ye = cmd_i.end_y[COORD_BITS-1:0];

  assign twice = WideW'(err_q) <<< 1;
  assign dx_w  = signed'(WideW'(span_x_q));
  assign dy_w  = signed'(WideW'(span_y_q));

  always_comb begin
    busy_d     = busy_q;
    axis_run_d = axis_run_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    tgt_x_d    = tgt_x_q;
    tgt_y_d    = tgt_y_q;
    span_x_d   = span_x_q;
    span_y_d   = span_y_q;
    x_down_d   = x_down_q;
    y_down_d   = y_down_q;
    err_d      = err_q;
    err_w      = WideW'(err_q);
    if (accept && (cmd_i.operation == OP_START)) begin
      busy_d = 1'b1;
      if ((xs == xe) || (ys == ye)) begin
        axis_run_d = 1'b1;
        cur_x_d    = (xs < xe) ? xs : xe;
        tgt_x_d    = (xs < xe) ? xe : xs;
        cur_y_d    = (ys < ye) ? ys : ye;
        tgt_y_d    = (ys < ye) ? ye : ys;
        span_x_d   = '0;
        span_y_d   = '0;
        x_down_d   = 1'b0;
        y_down_d   = 1'b0;
        err_d      = '0;
      end else begin
        axis_run_d = 1'b0;
        cur_x_d    = xs;
        cur_y_d    = ys;
        tgt_x_d    = xe;
        tgt_y_d    = ye;
        x_down_d   = !(xs < xe);
        y_down_d   = !(ys < ye);
        span_x_d   = (xs < xe) ? (xe - xs) : (xs - xe);
        span_y_d   = (ys < ye) ? (ye - ys) : (ys - ye);
        err_d      = signed'(ErrW'(span_x_d)) - signed'(ErrW'(span_y_d));
      end
    end else if (emit) begin
      if (last) begin
        busy_d = 1'b0;
      end else if (axis_run_q) begin
        if (cur_x_q != tgt_x_q) begin
          cur_x_d = cur_x_q + 1'b1;
        end else begin
          cur_y_d = cur_y_q + 1'b1;
        end
      end else begin
        if (twice > -dy_w) begin
          err_w   = err_w - dy_w;
          cur_x_d = x_down_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
        end
        if (twice < dx_w) begin
          err_w   = err_w + dx_w;
          cur_y_d = y_down_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);
        end
        err_d = err_w[ErrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (cfg_i.valid && cfg_i.ready) begin
        color_q <= cfg_i.data;
      end
      if (cmd_i.ready) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    axis_run_q <= axis_run_d;
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    tgt_x_q    <= tgt_x_d;
    tgt_y_q    <= tgt_y_d;
    span_x_q   <= span_x_d;
    span_y_q   <= span_y_d;
    x_down_q   <= x_down_d;
    y_down_q   <= y_down_d;
    err_q      <= err_d;
    if (emit) begin
      out_x_q     <= FIELD_W'(cur_x_q);
      out_y_q     <= FIELD_W'(cur_y_q);
      out_color_q <= color_q;
      out_last_q  <= last;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.pixel_x      = out_x_q;
  assign pix_o.pixel_y      = out_y_q;
  assign pix_o.pixel_colour = out_color_q;
  assign pix_o.last_pixel   = out_last_q;

endmodule
